/* src/iq_overwrite_ring_buffer_macros.svh */
// Assertion macros shared by the I/Q overwrite ring buffer RTL.
`ifndef IQ_OVERWRITE_RING_BUFFER_MACROS_SVH
`define IQ_OVERWRITE_RING_BUFFER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IQORB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define IQORB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/iqorb_pkg.sv */
// Package with sizes, types and the byte quantizer of the I/Q ring buffer.
package iqorb_pkg;

    localparam int DEPTH     = 4096;
    localparam int MAX_BURST = 64;
    localparam int PTR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FILL_W    = $clog2(DEPTH + 1);
    localparam int CNT_W     = 7;
    localparam int CMP_W     = (FILL_W > CNT_W) ? FILL_W : CNT_W;
    localparam int SMP_W     = 16;
    localparam int BYTE_W    = 8;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_READ  = 1'b1;

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } t_state;

    typedef struct packed {
        logic signed [SMP_W-1:0]  raw_i;
        logic signed [SMP_W-1:0]  raw_q;
        logic        [BYTE_W-1:0] i_byte;
        logic        [BYTE_W-1:0] q_byte;
        logic                     has_data;
        logic                     last;
    } t_rsp;

    // Offset-binary byte with round half up: (255*(s+32768)+32768) >> 16.
    function automatic logic [BYTE_W-1:0] quantize(input logic [SMP_W-1:0] v);
        logic [SMP_W-1:0]  off;
        logic [23:0]       prod;
        logic [23:0]       sum;
        off  = v ^ 16'h8000;
        prod = {off, 8'h00} - {8'h00, off};
        sum  = prod + 24'h008000;
        return sum[23:16];
    endfunction

endpackage

/* src/iqorb_if.sv */
// Valid/ready channel interfaces for the request and result sides.
interface iqorb_req_if
    import iqorb_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic                    req_type;
    logic signed [SMP_W-1:0] in_i;
    logic signed [SMP_W-1:0] in_q;
    logic                    flush;
    logic [CNT_W-1:0]        read_count;

    modport source (output valid, req_type, in_i, in_q, flush, read_count, input ready);
    modport sink   (input valid, req_type, in_i, in_q, flush, read_count, output ready);
endinterface

interface iqorb_rsp_if
    import iqorb_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic signed [SMP_W-1:0]  raw_i;
    logic signed [SMP_W-1:0]  raw_q;
    logic        [BYTE_W-1:0] i_byte;
    logic        [BYTE_W-1:0] q_byte;
    logic                     has_data;
    logic                     last;

    modport source (output valid, raw_i, raw_q, i_byte, q_byte, has_data, last, input ready);
    modport sink   (input valid, raw_i, raw_q, i_byte, q_byte, has_data, last, output ready);
endinterface

/* src/iq_overwrite_ring_buffer.sv */
// Top level: overwrite-oldest circular buffer of I/Q pairs with burst reads.
//
// i_req carries write and read transactions; o_rsp carries result transactions.
// A write stores one pair and produces no result. With flush set on a write
// the buffer is emptied first. When the buffer is full a write drops the oldest
// pair. A read asks for up to 64 pairs (larger counts are cut to 64) and yields
// min(request, fill) results, the final one marked last; on an empty buffer it
// yields one result with has_data low. A read with a count of zero does nothing.
// A read burst streams one pair per cycle out of the sample memory while the
// output queue has room; with o_rsp.ready high the next transaction on i_req
// is accepted only after the N memory reads of a burst of N pairs and the
// return of the last one. The first result passes the burst state register,
// the memory read register and the output queue register.
// A two-entry output queue stands behind the memory; while o_rsp.ready is low
// the memory reads pause once the queue fills, nothing is lost, and i_req is held off once the
// queue is full, while a burst runs and while its last memory read returns.
// Reset clears the pointers, the full flag, the queue and the burst state.
// The sample memory is not cleared; only written entries are ever read.
module iq_overwrite_ring_buffer
    import iqorb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    iqorb_req_if.sink   i_req,
    iqorb_rsp_if.source o_rsp
);

    logic [31:0] mem [DEPTH];

    t_state             r_state, n_state;
    logic [PTR_W-1:0]   r_wptr, n_wptr;
    logic [PTR_W-1:0]   r_rptr, n_rptr;
    logic               r_full, n_full;
    logic [CNT_W-1:0]   r_left, n_left;
    logic               r_inflight, n_inflight;
    logic               r_inflight_last, n_inflight_last;
    logic [31:0]        r_rdata;
    t_rsp               r_q0, n_q0;
    t_rsp               r_q1, n_q1;
    logic [1:0]         r_qcnt, n_qcnt;

    logic               accept;
    logic               pop;
    logic               issue;
    logic               mem_we;
    logic [PTR_W-1:0]   widx;
    logic [PTR_W-1:0]   wnext;
    logic [PTR_W-1:0]   rbase;
    logic               full_base;
    logic [FILL_W-1:0]  fill;
    logic [CNT_W-1:0]   cnt_sat;
    logic [CNT_W-1:0]   got;
    logic [1:0]         occ;
    logic               push;
    t_rsp               push_data;
    t_rsp               empty_rsp;

    function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign accept = i_req.valid && i_req.ready;
    assign pop    = o_rsp.valid && o_rsp.ready;
    assign occ    = r_qcnt + {1'b0, r_inflight};

    // Fill level and the number of pairs a read will return.
    always_comb begin
        if (r_full) begin
            fill = FILL_W'(DEPTH);
        end else if (r_wptr >= r_rptr) begin
            fill = FILL_W'(r_wptr) - FILL_W'(r_rptr);
        end else begin
            fill = FILL_W'(DEPTH) - FILL_W'(r_rptr) + FILL_W'(r_wptr);
        end
        cnt_sat = (i_req.read_count > CNT_W'(MAX_BURST)) ? CNT_W'(MAX_BURST)
                                                         : i_req.read_count;
        got = (CMP_W'(fill) < CMP_W'(cnt_sat)) ? CNT_W'(fill) : cnt_sat;
    end

    // Write path: a flush restarts both pointers before the pair is stored.
    always_comb begin
        widx      = i_req.flush ? '0 : r_wptr;
        rbase     = i_req.flush ? '0 : r_rptr;
        full_base = i_req.flush ? 1'b0 : r_full;
        wnext     = ptr_next(widx);
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept && i_req.req_type == REQ_READ && got != '0) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                if (issue && r_left == CNT_W'(1)) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer: handshake, memory strobes, pointer updates.
    always_comb begin
        i_req.ready     = 1'b0;
        issue           = 1'b0;
        mem_we          = 1'b0;
        n_wptr          = r_wptr;
        n_rptr          = r_rptr;
        n_full          = r_full;
        n_left          = r_left;
        push            = 1'b0;
        empty_rsp       = '0;
        empty_rsp.last  = 1'b1;
        case (r_state)
            ST_IDLE: begin
                i_req.ready = !r_inflight && (r_qcnt < 2'd2);
                if (accept) begin
                    if (i_req.req_type == REQ_WRITE) begin
                        mem_we = 1'b1;
                        n_wptr = wnext;
                        n_rptr = full_base ? ptr_next(rbase) : rbase;
                        n_full = full_base || (wnext == (full_base ? ptr_next(rbase) : rbase));
                    end else if (i_req.read_count != '0) begin
                        if (fill == '0) begin
                            push = 1'b1;
                        end else begin
                            n_left = got;
                            n_full = 1'b0;
                        end
                    end
                end
            end
            ST_READ: begin
                // Issue while the queue plus the read in flight leave a free slot.
                issue = (occ < 2'd2) || (occ == 2'd2 && pop);
                if (issue) begin
                    n_rptr = ptr_next(r_rptr);
                    n_left = r_left - CNT_W'(1);
                end
            end
            default: ;
        endcase
        n_inflight      = issue;
        n_inflight_last = issue && (r_left == CNT_W'(1));
    end

    // Sample memory, one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[widx] <= {i_req.in_i, i_req.in_q};
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_rdata <= mem[r_rptr];
        end
    end

    // Output queue: memory returns and empty-buffer results enter here.
    always_comb begin
        if (r_inflight) begin
            push_data.raw_i    = r_rdata[31:16];
            push_data.raw_q    = r_rdata[15:0];
            push_data.i_byte   = quantize(r_rdata[31:16]);
            push_data.q_byte   = quantize(r_rdata[15:0]);
            push_data.has_data = 1'b1;
            push_data.last     = r_inflight_last;
        end else begin
            push_data = empty_rsp;
        end
    end

    always_comb begin
        n_q0   = r_q0;
        n_q1   = r_q1;
        n_qcnt = r_qcnt;
        case ({push || r_inflight, pop})
            2'b10: begin
                if (r_qcnt == 2'd0) begin
                    n_q0 = push_data;
                end else begin
                    n_q1 = push_data;
                end
                n_qcnt = r_qcnt + 2'd1;
            end
            2'b01: begin
                n_q0   = r_q1;
                n_qcnt = r_qcnt - 2'd1;
            end
            2'b11: begin
                if (r_qcnt == 2'd1) begin
                    n_q0 = push_data;
                end else begin
                    n_q0 = r_q1;
                    n_q1 = push_data;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_IDLE;
            r_wptr          <= '0;
            r_rptr          <= '0;
            r_full          <= 1'b0;
            r_left          <= '0;
            r_inflight      <= 1'b0;
            r_inflight_last <= 1'b0;
            r_qcnt          <= '0;
        end else begin
            r_state         <= n_state;
            r_wptr          <= n_wptr;
            r_rptr          <= n_rptr;
            r_full          <= n_full;
            r_left          <= n_left;
            r_inflight      <= n_inflight;
            r_inflight_last <= n_inflight_last;
            r_qcnt          <= n_qcnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q0 <= n_q0;
        r_q1 <= n_q1;
    end

    assign o_rsp.valid    = (r_qcnt != 2'd0);
    assign o_rsp.raw_i    = r_q0.raw_i;
    assign o_rsp.raw_q    = r_q0.raw_q;
    assign o_rsp.i_byte   = r_q0.i_byte;
    assign o_rsp.q_byte   = r_q0.q_byte;
    assign o_rsp.has_data = r_q0.has_data;
    assign o_rsp.last     = r_q0.last;

`include "iq_overwrite_ring_buffer_macros.svh"

    `IQORB_ASSERT_NOW(a_full_ptrs_equal, i_clk, i_rst_n, r_full, r_wptr == r_rptr, "full flag set with unequal pointers")
    `IQORB_ASSERT_NOW(a_queue_bound, i_clk, i_rst_n, 1'b1, occ <= 2'd2, "output queue overcommitted")
    `IQORB_ASSERT_NOW(a_return_has_slot, i_clk, i_rst_n, r_inflight, r_qcnt < 2'd2 || pop, "memory return with no queue slot")
    `IQORB_ASSERT_NEXT(a_burst_ends, i_clk, i_rst_n, issue && r_left == CNT_W'(1), r_state == ST_IDLE && r_inflight_last, "burst did not end after its last read")

endmodule

/* sim/iq_overwrite_ring_buffer_tb.sv */
// Self-checking testbench for the I/Q overwrite ring buffer with a predictor of its contents.
module iq_overwrite_ring_buffer_tb;
    import iqorb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        bit               pause;
        logic             req_type;
        logic [SMP_W-1:0] in_i;
        logic [SMP_W-1:0] in_q;
        logic             flush;
        logic [CNT_W-1:0] read_count;
    } t_req_item;

    logic clk;
    logic rst_n;

    iqorb_req_if req_ch ();
    iqorb_rsp_if rsp_ch ();

    iq_overwrite_ring_buffer u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    // Pending transactions for the driver and results the buffer contents predict.
    t_req_item stim_q[$];
    t_rsp      predicted_pairs[$];

    // Shadow copy of the ring buffer.
    logic [2*SMP_W-1:0] shadow_store [DEPTH];
    int                 shadow_wr;
    int                 shadow_rd;
    bit                 shadow_full;

    int  err_count;
    int  writes_seen;
    int  reads_seen;
    int  results_seen;
    int  flushes_seen;
    int  overwrites_seen;
    int  empty_reads;
    int  full_reads;
    int  gap_left;
    int  stall_left;
    int  calm_left;
    bit  draining;
    bit  req_taken;

    always #5 clk = ~clk;

    function automatic logic [BYTE_W-1:0] offset_byte(input logic [SMP_W-1:0] v);
        int unsigned off;
        int unsigned scaled;
        off    = int'(v ^ 16'h8000);
        scaled = (255 * off + 32768) >> 16;
        return scaled[BYTE_W-1:0];
    endfunction

    // Idle length: mostly none or short, now and then long, none during calm stretches.
    function automatic int pick_idle();
        int r;
        if (calm_left > 0) return 0;
        r = $urandom_range(0, 15);
        if (r == 0) return $urandom_range(10, 40);
        if (r < 6) return $urandom_range(1, 3);
        return 0;
    endfunction

    function automatic logic [SMP_W-1:0] pick_sample();
        logic [31:0] v;
        v = $urandom();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'(int'($urandom_range(0, 16)) - 8);
            default: return v[SMP_W-1:0];
        endcase
    endfunction

    function automatic logic [CNT_W-1:0] pick_count();
        case ($urandom_range(0, 15))
            0: return '0;
            1: return CNT_W'($urandom_range(MAX_BURST + 1, 127));
            2: return CNT_W'(MAX_BURST);
            default: return CNT_W'($urandom_range(1, 16));
        endcase
    endfunction

    task automatic push_write(input logic [SMP_W-1:0] vi, input logic [SMP_W-1:0] vq,
                              input logic fl);
        t_req_item it;
        it.pause      = 1'b0;
        it.req_type   = REQ_WRITE;
        it.in_i       = vi;
        it.in_q       = vq;
        it.flush      = fl;
        it.read_count = pick_count();
        stim_q.push_back(it);
    endtask

    task automatic push_read(input logic [CNT_W-1:0] cnt, input logic fl);
        t_req_item it;
        it.pause      = 1'b0;
        it.req_type   = REQ_READ;
        it.in_i       = pick_sample();
        it.in_q       = pick_sample();
        it.flush      = fl;
        it.read_count = cnt;
        stim_q.push_back(it);
    endtask

    task automatic push_pause();
        t_req_item it;
        it          = '{default: '0};
        it.pause    = 1'b1;
        stim_q.push_back(it);
    endtask

    task automatic predict_ring_access(input logic rtype, input logic [SMP_W-1:0] vi,
                                       input logic [SMP_W-1:0] vq, input logic fl,
                                       input logic [CNT_W-1:0] rc);
        int                 cnt;
        int                 avail;
        int                 got;
        logic [2*SMP_W-1:0] w;
        t_rsp               r;
        if (rtype == REQ_WRITE) begin
            writes_seen++;
            if (fl) begin
                shadow_wr   = 0;
                shadow_rd   = 0;
                shadow_full = 1'b0;
                flushes_seen++;
            end
            shadow_store[shadow_wr] = {vi, vq};
            shadow_wr = (shadow_wr + 1 == DEPTH) ? 0 : shadow_wr + 1;
            if (shadow_full) begin
                shadow_rd = (shadow_rd + 1 == DEPTH) ? 0 : shadow_rd + 1;
                overwrites_seen++;
            end
            if (shadow_wr == shadow_rd) shadow_full = 1'b1;
        end else begin
            reads_seen++;
            cnt = int'(rc);
            if (cnt > MAX_BURST) cnt = MAX_BURST;
            avail = shadow_full ? DEPTH : (shadow_wr - shadow_rd + DEPTH) % DEPTH;
            if (cnt != 0 && avail == 0) begin
                r      = '0;
                r.last = 1'b1;
                predicted_pairs.push_back(r);
                empty_reads++;
            end else if (cnt != 0) begin
                if (shadow_full) full_reads++;
                got = (cnt < avail) ? cnt : avail;
                for (int k = 0; k < got; k++) begin
                    w          = shadow_store[shadow_rd];
                    r.raw_i    = w[2*SMP_W-1:SMP_W];
                    r.raw_q    = w[SMP_W-1:0];
                    r.i_byte   = offset_byte(w[2*SMP_W-1:SMP_W]);
                    r.q_byte   = offset_byte(w[SMP_W-1:0]);
                    r.has_data = 1'b1;
                    r.last     = (k == got - 1);
                    predicted_pairs.push_back(r);
                    shadow_rd = (shadow_rd + 1 == DEPTH) ? 0 : shadow_rd + 1;
                end
                shadow_full = 1'b0;
            end
        end
    endtask

    task automatic check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            err_count++;
            if (err_count <= 100) begin
                $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                         $time, name, exp_v, act_v);
            end
        end
    endtask

    // Transaction monitor: runs the predictor on accepted requests and checks results.
    always @(posedge clk) begin
        t_rsp e;
        req_taken = 1'b0;
        if (rst_n) begin
            if (req_ch.valid && req_ch.ready) begin
                req_taken = 1'b1;
                predict_ring_access(req_ch.req_type, req_ch.in_i, req_ch.in_q,
                                    req_ch.flush, req_ch.read_count);
            end
            if (rsp_ch.valid && rsp_ch.ready) begin
                results_seen++;
                if (predicted_pairs.size() == 0) begin
                    err_count++;
                    if (err_count <= 100) begin
                        $display("%0t ns: unexpected result, expected none, actual i=%0d q=%0d",
                                 $time, rsp_ch.raw_i, rsp_ch.raw_q);
                    end
                end else begin
                    e = predicted_pairs.pop_front();
                    check_field("raw_i", int'(e.raw_i), int'(rsp_ch.raw_i));
                    check_field("raw_q", int'(e.raw_q), int'(rsp_ch.raw_q));
                    check_field("i_byte", int'(e.i_byte), int'(rsp_ch.i_byte));
                    check_field("q_byte", int'(e.q_byte), int'(rsp_ch.q_byte));
                    check_field("has_data", int'(e.has_data), int'(rsp_ch.has_data));
                    check_field("last", int'(e.last), int'(rsp_ch.last));
                end
            end
        end
    end

    // Request driver.
    always @(negedge clk) begin
        t_req_item nxt;
        bit        load;
        load = 1'b0;
        if (rst_n) begin
            if (req_ch.valid && !req_taken) begin
                // Transaction still waiting for ready.
            end else if (gap_left > 0) begin
                gap_left--;
            end else if (draining) begin
                if (predicted_pairs.size() == 0) draining = 1'b0;
            end else if (stim_q.size() != 0) begin
                nxt = stim_q.pop_front();
                if (nxt.pause) begin
                    draining = 1'b1;
                end else begin
                    load     = 1'b1;
                    gap_left = pick_idle();
                end
            end
        end
        if (load) begin
            req_ch.req_type   <= nxt.req_type;
            req_ch.in_i       <= nxt.in_i;
            req_ch.in_q       <= nxt.in_q;
            req_ch.flush      <= nxt.flush;
            req_ch.read_count <= nxt.read_count;
            req_ch.valid      <= 1'b1;
        end else if (!(req_ch.valid && !req_taken)) begin
            req_ch.valid <= 1'b0;
        end
    end

    // Result-side back-pressure, with occasional calm stretches without any idling.
    always @(negedge clk) begin
        if (calm_left > 0) begin
            calm_left--;
        end else if ($urandom_range(0, 999) == 0) begin
            calm_left = $urandom_range(100, 400);
        end
        if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
        end else begin
            rsp_ch.ready <= 1'b1;
            if ($urandom_range(0, 7) == 0) stall_left = pick_idle();
        end
    end

    initial begin
        #50_000_000;
        $display("FAILURE");
        $finish;
    end

    initial begin
        int items;
        int k;
        clk               = 1'b0;
        rst_n             = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.req_type   = REQ_WRITE;
        req_ch.in_i       = '0;
        req_ch.in_q       = '0;
        req_ch.flush      = 1'b0;
        req_ch.read_count = '0;
        rsp_ch.ready      = 1'b0;
        shadow_wr         = 0;
        shadow_rd         = 0;
        shadow_full       = 1'b0;
        err_count         = 0;
        writes_seen       = 0;
        reads_seen        = 0;
        results_seen      = 0;
        flushes_seen      = 0;
        overwrites_seen   = 0;
        empty_reads       = 0;
        full_reads        = 0;
        gap_left          = 0;
        stall_left        = 0;
        calm_left         = 0;
        draining          = 1'b0;
        req_taken         = 1'b0;

        // Directed: empty reads, zero and oversized counts, sample extremes, flush cases.
        push_read(7'd1, 1'b0);
        push_read(7'd0, 1'b0);
        push_read(7'd127, 1'b1);
        push_write(16'h8000, 16'h7fff, 1'b0);
        push_write(16'h7fff, 16'h8000, 1'b0);
        push_write(16'h0000, 16'hffff, 1'b0);
        push_write(16'h0080, 16'hff80, 1'b0);
        push_write(16'h0001, 16'h8001, 1'b0);
        push_read(7'd0, 1'b0);
        push_read(7'd127, 1'b0);
        push_read(7'd1, 1'b1);
        push_write(16'h1234, 16'hedcb, 1'b0);
        push_write(16'h5555, 16'haaaa, 1'b1);
        push_write(16'haaaa, 16'h5555, 1'b0);
        push_write(16'h7ffe, 16'h8002, 1'b1);
        push_read(7'd1, 1'b0);
        push_read(7'd1, 1'b0);
        push_write(16'h00ff, 16'hff00, 1'b0);
        push_write(16'h0100, 16'hfeff, 1'b0);
        push_write(16'h4000, 16'hc000, 1'b0);
        push_read(7'd2, 1'b0);
        push_read(7'd64, 1'b0);
        push_read(7'd65, 1'b0);
        push_pause();

        // Random sequences of writes, flushes and reads.
        items = 0;
        while (items < 300) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    k = $urandom_range(1, 12);
                    push_write(pick_sample(), pick_sample(), ($urandom_range(0, 7) == 0));
                    for (int n = 1; n < k; n++) push_write(pick_sample(), pick_sample(), 1'b0);
                    items += k;
                end
                4, 5: begin
                    push_read(pick_count(), 1'($urandom_range(0, 1)));
                    items++;
                end
                6: begin
                    k = $urandom_range(1, 8);
                    for (int n = 0; n < k; n++) push_write(pick_sample(), pick_sample(), 1'b0);
                    push_read(CNT_W'(k), 1'b0);
                    push_read(7'd1, 1'b0);
                    items += k + 2;
                end
                7: begin
                    for (int n = 0; n < 3; n++) push_read(CNT_W'(MAX_BURST), 1'($urandom_range(0, 1)));
                    items += 3;
                end
                8: begin
                    push_pause();
                end
                default: begin
                    push_write(pick_sample(), pick_sample(), 1'b1);
                    push_read(pick_count(), 1'b0);
                    items += 2;
                end
            endcase
        end

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (stim_q.size() != 0 || draining || req_ch.valid) @(posedge clk);
        while (predicted_pairs.size() != 0) @(posedge clk);
        repeat (50) @(posedge clk);

        if (predicted_pairs.size() != 0) begin
            err_count++;
            $display("%0t ns: missing results, expected %0d more, actual 0",
                     $time, predicted_pairs.size());
        end
        $display("Covered %0d writes (%0d flushes, %0d overwrites of the oldest pair) and %0d reads",
                 writes_seen, flushes_seen, overwrites_seen, reads_seen);
        $display("Checked %0d results, %0d empty-buffer reads, %0d reads of a full buffer",
                 results_seen, empty_reads, full_reads);
        if (err_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+src
src/iqorb_pkg.sv
src/iqorb_if.sv
src/iq_overwrite_ring_buffer.sv
sim/iq_overwrite_ring_buffer_tb.sv
